// ===== rtl/sid_pkg.sv =====
// ----------------------------------------------------------------------------
// sid_pkg - sub-band incoherent dedisperser shared definitions
// Widths, sizes and register codes used across the dedisperser core.
// ----------------------------------------------------------------------------
package sid_pkg;

	// sizes
	localparam int MAX_CHANNELS = 1024;
	localparam int MAX_BANDS    = 16;
	localparam int DELAY_ROWS   = 1024;
	localparam int SAMPLE_BITS  = 16;

	// field widths
	localparam int CHAN_BITS    = 10;
	localparam int DELAY_BITS   = 10;
	localparam int SAMPLE_W     = 16;
	localparam int SUM_BITS     = 26;
	localparam int BAND_W       = 6;
	localparam int CPB_BITS     = 11;
	localparam int BC_BITS      = 7;
	localparam int SHIFT_BITS   = 10;
	localparam int WARM_BITS    = 11;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DAT_BITS = 11;

	// derived widths
	localparam int ROW_BITS      = $clog2(DELAY_ROWS);
	localparam int BAND_BITS     = $clog2(MAX_BANDS);
	localparam int NB_BITS       = $clog2(MAX_BANDS + 1);
	localparam int ACC_ADDR_BITS = ROW_BITS + BAND_BITS;
	localparam int ACC_DEPTH     = DELAY_ROWS * MAX_BANDS;
	localparam int TOT_BITS      = NB_BITS + CPB_BITS;
	localparam int DIV_BITS      = CPB_BITS + BAND_BITS;
	localparam int STEP_BITS     = (BAND_BITS > 1) ? $clog2(BAND_BITS) : 1;
	localparam int TBL_BITS      = DELAY_BITS + 1;

	localparam logic [WARM_BITS-1:0] WARM_MAX = '1;
	localparam logic [SUM_BITS-1:0]  SUM_MAX  = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_CPB   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_BANDS = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT = 2'd2;

	// item kinds
	localparam logic KIND_TABLE  = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

endpackage

// ===== rtl/subband_incoherent_dedisperser_core.sv =====
// ----------------------------------------------------------------------------
// subband_incoherent_dedisperser_core
// Delays each filterbank channel by a per-channel table value, sums channels
// into sub-bands in a row-per-time accumulator memory, and emits one row of
// sub-band sums per completed spectrum once the max-shift window has filled.
// ----------------------------------------------------------------------------
//
// Channel  | Handshake           | Payload
// ---------+---------------------+------------------------------------------
// item     | item_valid/stall    | kind, channel, delay, skip_channel, sample
// result   | result_valid/stall  | band, band_sum, last
// cfg      | cfg_valid/ready     | cfg_index, cfg_data
//
// Table-write items are written directly. A sample item runs through a table
// read, a 4-step channel/channels_per_band divider, then an accumulator
// read-modify-write on the accumulator memory (no write for an ignored
// channel; a channel out of range goes back to idle after the range check).
// The last channel of a spectrum then visits every sub-band slot
// (MAX_BANDS slots: read, then emit and clear) and waits out any result stall.
// After reset a clearing pass over all ACC_DEPTH (16384) addresses zeroes the
// accumulators and channel table; items stall, cfg writes are taken.
// ----------------------------------------------------------------------------
module subband_incoherent_dedisperser_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// item channel
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic                                 kind,
	input  logic [sid_pkg::CHAN_BITS-1:0]        channel,
	input  logic [sid_pkg::DELAY_BITS-1:0]       delay,
	input  logic                                 skip_channel,
	input  logic [sid_pkg::SAMPLE_W-1:0]         sample,
	// result channel
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [sid_pkg::BAND_W-1:0]           band,
	output logic [sid_pkg::SUM_BITS-1:0]         band_sum,
	output logic                                 last,
	// configuration channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [sid_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [sid_pkg::CFG_DAT_BITS-1:0]     cfg_data
);
	import sid_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_ACC_RD,
		S_ACC_WR,
		S_EMIT_RD,
		S_EMIT_WR
	} state_t;

	state_t state_q;

	// configuration registers
	logic [CPB_BITS-1:0]   cpb_q;
	logic [BC_BITS-1:0]    band_count_q;
	logic [SHIFT_BITS-1:0] max_shift_q;

	// sequencer state
	logic [ACC_ADDR_BITS-1:0] clr_q;
	logic [CHAN_BITS-1:0]     ch_q;
	logic [SAMPLE_BITS-1:0]   sample_q;
	logic [CHAN_BITS-1:0]     rem_q;
	logic [BAND_BITS-1:0]     quot_q;
	logic [STEP_BITS-1:0]     step_q;
	logic [ACC_ADDR_BITS-1:0] acc_addr_q;
	logic [ROW_BITS-1:0]      row_ptr_q;
	logic [WARM_BITS-1:0]     warm_q;
	logic [ROW_BITS-1:0]      out_row_q;
	logic [BAND_BITS-1:0]     b_q;
	logic                     emit_q;
	logic                     out_valid_q;

	// memories
	logic [TBL_BITS-1:0] tbl_mem [MAX_CHANNELS];
	logic [TBL_BITS-1:0] tbl_rdata_q;
	logic [SUM_BITS-1:0] acc_mem [ACC_DEPTH];
	logic [SUM_BITS-1:0] acc_rdata_q;

	// effective configuration
	logic [CPB_BITS-1:0]   cpb_eff;
	logic [BC_BITS-1:0]    bc_nz;
	logic [NB_BITS-1:0]    nb_eff;
	logic [SHIFT_BITS-1:0] shift_eff;
	logic [TOT_BITS-1:0]   total;
	logic                  ch_in_range;
	logic                  ch_last;

	// datapath
	logic [DIV_BITS-1:0]      div_trial;
	logic                     div_ge;
	logic [DELAY_BITS-1:0]    tbl_delay;
	logic                     tbl_skip;
	logic [DELAY_BITS-1:0]    d_eff;
	logic [ROW_BITS-1:0]      sample_row;
	logic [SUM_BITS:0]        acc_sum;
	logic [SUM_BITS-1:0]      acc_sat;
	logic                     item_acc;
	logic                     tbl_we;
	logic [CHAN_BITS-1:0]     tbl_waddr;
	logic [TBL_BITS-1:0]      tbl_wdata;
	logic [DELAY_BITS-1:0]    delay_clamped;
	logic                     acc_re;
	logic [ACC_ADDR_BITS-1:0] acc_raddr;
	logic                     acc_we;
	logic [ACC_ADDR_BITS-1:0] acc_waddr;
	logic [SUM_BITS-1:0]      acc_wdata;
	logic                     use_band;
	logic                     out_free;
	logic                     proceed;
	logic                     out_load;

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != S_IDLE);
	assign item_acc     = item_valid && !item_stall;
	assign result_valid = out_valid_q;

	// effective register values (zero acts as one, clamp to storage)
	always_comb begin
		cpb_eff   = (cpb_q == '0) ? CPB_BITS'(1) : cpb_q;
		bc_nz     = (band_count_q == '0) ? BC_BITS'(1) : band_count_q;
		nb_eff    = (bc_nz > BC_BITS'(MAX_BANDS)) ? NB_BITS'(MAX_BANDS) : bc_nz[NB_BITS-1:0];
		shift_eff = (max_shift_q > SHIFT_BITS'(DELAY_ROWS - 1)) ?
			SHIFT_BITS'(DELAY_ROWS - 1) : max_shift_q;
		total       = TOT_BITS'(nb_eff) * TOT_BITS'(cpb_eff);
		ch_in_range = TOT_BITS'(ch_q) < total;
		ch_last     = TOT_BITS'(ch_q) == (total - TOT_BITS'(1));
	end

	// one restoring step of channel / channels_per_band
	assign div_trial = DIV_BITS'(cpb_eff) << step_q;
	assign div_ge    = DIV_BITS'(rem_q) >= div_trial;

	// delay lookup and accumulator row
	always_comb begin
		tbl_delay  = tbl_rdata_q[DELAY_BITS-1:0];
		tbl_skip   = tbl_rdata_q[DELAY_BITS];
		d_eff      = (tbl_delay > shift_eff) ? shift_eff : tbl_delay;
		sample_row = row_ptr_q - ROW_BITS'(d_eff);
		acc_sum    = {1'b0, acc_rdata_q} + (SUM_BITS + 1)'(sample_q);
		acc_sat    = acc_sum[SUM_BITS] ? SUM_MAX : acc_sum[SUM_BITS-1:0];
	end

	// emission handshake
	always_comb begin
		use_band = emit_q && ({1'b0, b_q} < nb_eff);
		out_free = !out_valid_q || !result_stall;
		proceed  = !use_band || out_free;
		out_load = (state_q == S_EMIT_WR) && use_band && out_free;
	end

	// channel table write port
	always_comb begin
		delay_clamped = (delay > max_shift_q) ? max_shift_q : delay;
		tbl_we    = 1'b0;
		tbl_waddr = channel;
		tbl_wdata = {skip_channel, delay_clamped};
		if (state_q == S_CLEAR) begin
			tbl_we    = 1'b1;
			tbl_waddr = clr_q[CHAN_BITS-1:0];
			tbl_wdata = '0;
		end else if (item_acc && kind == KIND_TABLE) begin
			tbl_we = 1'b1;
		end
	end

	// accumulator read and write ports
	always_comb begin
		acc_re    = 1'b0;
		acc_raddr = {sample_row, quot_q};
		acc_we    = 1'b0;
		acc_waddr = acc_addr_q;
		acc_wdata = acc_sat;
		unique case (state_q)
			S_CLEAR: begin
				acc_we    = 1'b1;
				acc_waddr = clr_q;
				acc_wdata = '0;
			end
			S_ACC_RD: begin
				acc_re = !tbl_skip;
			end
			S_ACC_WR: begin
				acc_we = 1'b1;
			end
			S_EMIT_RD: begin
				acc_re    = 1'b1;
				acc_raddr = {out_row_q, b_q};
			end
			S_EMIT_WR: begin
				acc_we    = proceed;
				acc_waddr = {out_row_q, b_q};
				acc_wdata = '0;
			end
			default: begin
			end
		endcase
	end

	// channel table memory
	always_ff @(posedge clk) begin
		if (tbl_we)
			tbl_mem[tbl_waddr] <= tbl_wdata;
		if (state_q == S_CHECK)
			tbl_rdata_q <= tbl_mem[ch_q];
	end

	// accumulator memory
	always_ff @(posedge clk) begin
		if (acc_we)
			acc_mem[acc_waddr] <= acc_wdata;
		if (acc_re)
			acc_rdata_q <= acc_mem[acc_raddr];
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			band     <= BAND_W'(b_q);
			band_sum <= acc_rdata_q;
			last     <= ({1'b0, b_q} == nb_eff - NB_BITS'(1));
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpb_q        <= CPB_BITS'(1);
			band_count_q <= BC_BITS'(1);
			max_shift_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CPB:   cpb_q        <= cfg_data[CPB_BITS-1:0];
				REG_BANDS: band_count_q <= cfg_data[BC_BITS-1:0];
				REG_SHIFT: max_shift_q  <= cfg_data[SHIFT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			ch_q        <= '0;
			sample_q    <= '0;
			rem_q       <= '0;
			quot_q      <= '0;
			step_q      <= '0;
			acc_addr_q  <= '0;
			row_ptr_q   <= '0;
			warm_q      <= '0;
			out_row_q   <= '0;
			b_q         <= '0;
			emit_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !result_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ACC_ADDR_BITS'(1);
					if (clr_q == '1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (item_acc && kind == KIND_SAMPLE) begin
						ch_q     <= channel;
						sample_q <= sample[SAMPLE_BITS-1:0];
						state_q  <= S_CHECK;
					end
				end
				S_CHECK: begin
					// table read issued here
					rem_q   <= ch_q;
					quot_q  <= '0;
					step_q  <= STEP_BITS'(BAND_BITS - 1);
					state_q <= ch_in_range ? S_DIV : S_IDLE;
				end
				S_DIV: begin
					if (div_ge) begin
						rem_q          <= rem_q - div_trial[CHAN_BITS-1:0];
						quot_q[step_q] <= 1'b1;
					end
					step_q <= step_q - STEP_BITS'(1);
					if (step_q == '0)
						state_q <= S_ACC_RD;
				end
				S_ACC_RD: begin
					acc_addr_q <= {sample_row, quot_q};
					if (!tbl_skip) begin
						state_q <= S_ACC_WR;
					end else if (ch_last) begin
						b_q       <= '0;
						out_row_q <= row_ptr_q - ROW_BITS'(shift_eff);
						emit_q    <= warm_q >= WARM_BITS'(shift_eff);
						state_q   <= S_EMIT_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_ACC_WR: begin
					if (ch_last) begin
						b_q       <= '0;
						out_row_q <= row_ptr_q - ROW_BITS'(shift_eff);
						emit_q    <= warm_q >= WARM_BITS'(shift_eff);
						state_q   <= S_EMIT_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_WR;
				end
				S_EMIT_WR: begin
					// wait here while the output register is full
					if (proceed) begin
						if (b_q == '1) begin
							row_ptr_q <= row_ptr_q + ROW_BITS'(1);
							if (warm_q != WARM_MAX)
								warm_q <= warm_q + WARM_BITS'(1);
							state_q <= S_IDLE;
						end else begin
							b_q     <= b_q + BAND_BITS'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// the row pointer only ever steps by one row
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		(row_ptr_q != $past(row_ptr_q)) |-> (row_ptr_q == $past(row_ptr_q) + ROW_BITS'(1)))
		else $error("row pointer jumped");

	// a new result appears only out of the emit step
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == S_EMIT_WR))
		else $error("result raised outside emission");

	// nothing is emitted while the clearing pass runs
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (!out_valid_q && item_stall))
		else $error("activity during clearing pass");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - regression for subband_incoherent_dedisperser_core
// Feeds delay-table writes and filterbank samples, spectrum by spectrum, under
// a range of channels-per-band, band-count and max-shift settings. Each
// accepted item runs through a local dedispersion predictor, and every
// sub-band sum leaving the core is compared against the oldest predicted one.
// A short directed table comes first, then random spectra with noise items,
// random idling and one long result hold.
// ----------------------------------------------------------------------------
module testbench;
	import sid_pkg::*;

	// index 3 has no register behind it; writes must be harmless
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

	typedef enum {ROW_ITEM, ROW_CFG} row_op_t;

	typedef struct {
		logic                  kind;
		logic [CHAN_BITS-1:0]  channel;
		logic [DELAY_BITS-1:0] dly;
		logic                  skip;
		logic [SAMPLE_W-1:0]   smp;
	} item_t;

	typedef struct {
		logic [BAND_W-1:0]   band;
		logic [SUM_BITS-1:0] sum;
		logic                last;
	} band_sum_t;

	// directed row: an item or a register write, with an optional typed result
	typedef struct {
		row_op_t                 op;
		logic                    kind;
		logic [CHAN_BITS-1:0]    channel;
		logic [DELAY_BITS-1:0]   dly;
		logic                    skip;
		logic [SAMPLE_W-1:0]     smp;
		logic [CFG_IDX_BITS-1:0] ridx;
		logic [CFG_DAT_BITS-1:0] rval;
		bit                      typed;
		int                      n_exp;
		logic [SUM_BITS-1:0]     esum;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid, item_stall;
	logic kind;
	logic [CHAN_BITS-1:0] channel;
	logic [DELAY_BITS-1:0] delay;
	logic skip_channel;
	logic [SAMPLE_W-1:0] sample;
	logic result_valid, result_stall;
	logic [BAND_W-1:0] band;
	logic [SUM_BITS-1:0] band_sum;
	logic last;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DAT_BITS-1:0] cfg_data;

	// predictor state
	logic [CPB_BITS-1:0] cpb_r;
	logic [BC_BITS-1:0] nbands_r;
	logic [SHIFT_BITS-1:0] shift_r;
	logic [DELAY_BITS-1:0] delay_mem [MAX_CHANNELS];
	bit skip_mem [MAX_CHANNELS];
	int unsigned sums [DELAY_ROWS][MAX_BANDS];
	int unsigned row_now, spectra_done;

	band_sum_t sums_due [$];
	band_sum_t head;
	step_t plan [24];
	int unsigned mismatches = 0;
	int unsigned fed = 0;
	bit busy = 1'b0;
	bit tx_calm = 1'b0, rx_calm = 1'b0;
	bit squeeze_req = 1'b0;

	subband_incoherent_dedisperser_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40) $display("%0t mismatch: %s", $time, msg);
	endtask

	// effective register values: zero acts as one, bands capped
	function automatic int unsigned eff_cpb();
		return (cpb_r == 0) ? 1 : cpb_r;
	endfunction

	function automatic int unsigned eff_bands();
		int unsigned b = (nbands_r == 0) ? 1 : nbands_r;
		return (b > MAX_BANDS) ? MAX_BANDS : b;
	endfunction

	function automatic int unsigned eff_shift();
		return (shift_r > DELAY_ROWS - 1) ? DELAY_ROWS - 1 : shift_r;
	endfunction

	// Advance the predictor by one item; queue the sub-band sums it releases.
	task automatic dedisperse_item(input item_t it, input bit emit, output bit used);
		int unsigned cpb, nb, sh, total, d, row, b;
		band_sum_t s;
		cpb = eff_cpb();
		nb = eff_bands();
		sh = eff_shift();
		total = nb * cpb;
		used = 1'b0;
		if (it.kind == KIND_TABLE) begin
			// delays are clamped against the raw register at write time
			delay_mem[it.channel] = (it.dly > shift_r) ? shift_r : it.dly;
			skip_mem[it.channel] = it.skip;
			used = 1'b1;
		end else if (it.channel < total) begin
			used = 1'b1;
			if (!skip_mem[it.channel]) begin
				d = delay_mem[it.channel];
				if (d > sh) d = sh;
				row = (row_now + DELAY_ROWS - d) % DELAY_ROWS;
				b = it.channel / cpb;
				sums[row][b] += it.smp;
				if (sums[row][b] > SUM_MAX) sums[row][b] = SUM_MAX;
			end
			// last channel closes the spectrum, releasing the oldest row
			if (it.channel == total - 1) begin
				row = (row_now + DELAY_ROWS - sh) % DELAY_ROWS;
				if (spectra_done >= sh && emit) begin
					for (b = 0; b < nb; b++) begin
						s.band = BAND_W'(b);
						s.sum = SUM_BITS'(sums[row][b]);
						s.last = (b == nb - 1);
						sums_due.push_back(s);
					end
				end
				for (b = 0; b < MAX_BANDS; b++) sums[row][b] = 0;
				row_now = (row_now + 1) % DELAY_ROWS;
				if (spectra_done < WARM_MAX) spectra_done++;
			end
		end
	endtask

	// Offer one item after a random gap; predict once it is taken.
	task automatic send_item(input item_t it, input bit emit);
		int unsigned gap;
		bit used;
		if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		kind <= it.kind;
		channel <= it.channel;
		delay <= it.dly;
		skip_channel <= it.skip;
		sample <= it.smp;
		do @(posedge clk); while (item_stall);
		dedisperse_item(it, emit, used);
		if (used) fed++;
		busy = 1'b1;
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DAT_BITS-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_CPB:   cpb_r = val[CPB_BITS-1:0];
			REG_BANDS: nbands_r = val[BC_BITS-1:0];
			REG_SHIFT: shift_r = val[SHIFT_BITS-1:0];
			default: ;
		endcase
	endtask

	// Let the core go idle: all sums delivered, then room for trailing work.
	task automatic quiesce();
		if (busy) begin
			item_valid <= 1'b0;
			while (sums_due.size() != 0) @(posedge clk);
			repeat (200) @(posedge clk);
			busy = 1'b0;
		end
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return '1;
			1: return '0;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic item_t sample_item(input int unsigned ch);
		item_t it;
		it.kind = KIND_SAMPLE;
		it.channel = CHAN_BITS'(ch);
		it.dly = DELAY_BITS'($urandom);
		it.skip = 1'($urandom);
		it.smp = pick_sample();
		return it;
	endfunction

	function automatic item_t noise_item();
		item_t it;
		it.kind = 1'($urandom);
		it.channel = CHAN_BITS'($urandom);
		it.dly = DELAY_BITS'($urandom);
		it.skip = 1'($urandom);
		it.smp = SAMPLE_W'($urandom);
		return it;
	endfunction

	// One setting: load delays, then stream spectra with some noise and
	// broken ordering until the quota of items is taken.
	task automatic run_phase(input logic [CFG_DAT_BITS-1:0] cpb_v,
			input logic [CFG_DAT_BITS-1:0] bands_v, input logic [CFG_DAT_BITS-1:0] shift_v,
			input int unsigned quota, input bit squeeze);
		int unsigned total, span, start, ch;
		item_t it;
		quiesce();
		write_reg(REG_CPB, cpb_v);
		write_reg(REG_BANDS, bands_v);
		write_reg(REG_SHIFT, shift_v);
		total = eff_cpb() * eff_bands();
		span = (total < 32) ? total : 32;
		start = fed;
		for (ch = 0; ch < span; ch++) begin
			it.kind = KIND_TABLE;
			it.channel = CHAN_BITS'(ch);
			it.dly = $urandom_range(0, 1) ? DELAY_BITS'($urandom_range(0, eff_shift()))
				: DELAY_BITS'($urandom);
			it.skip = ($urandom_range(0, 7) == 0);
			it.smp = SAMPLE_W'($urandom);
			send_item(it, 1'b1);
		end
		squeeze_req = squeeze;
		while (fed - start < quota) begin
			if (total > 64) begin
				send_item(sample_item($urandom_range(0, MAX_CHANNELS - 1)), 1'b1);
			end else begin
				for (ch = 0; ch < total; ch++) begin
					if ($urandom_range(0, 15) == 0) send_item(noise_item(), 1'b1);
					if ($urandom_range(0, 31) != 0) send_item(sample_item(ch), 1'b1);
					if ($urandom_range(0, 31) == 0) send_item(sample_item(ch), 1'b1);
				end
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (sums_due.size() == 0) begin
				flag_mismatch($sformatf("band %0d sum %0d with nothing due", band, band_sum));
			end else begin
				head = sums_due.pop_front();
				if (band !== head.band)
					flag_mismatch($sformatf("band %0d, want %0d", band, head.band));
				if (band_sum !== head.sum)
					flag_mismatch($sformatf("band %0d sum %0d, want %0d",
						head.band, band_sum, head.sum));
				if (last !== head.last)
					flag_mismatch($sformatf("band %0d last %0b, want %0b",
						head.band, last, head.last));
			end
		end
	end

	// result receiver: random holds, one long hold on request
	initial begin
		int unsigned hold;
		result_stall = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
			hold = rx_calm ? 0 : $urandom_range(0, 3);
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				hold = 600;
			end
			if (hold != 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	initial begin
		#5_000_000;
		$display("subband_incoherent_dedisperser_core regression: fail");
		$finish;
	end

	initial begin
		item_t it;
		int unsigned r, b, n;
		logic [CFG_DAT_BITS-1:0] cpb_v, bands_v, shift_v;
		arst_n = 1'b0;
		item_valid = 1'b0;
		kind = KIND_TABLE;
		channel = '0;
		delay = '0;
		skip_channel = 1'b0;
		sample = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_CPB;
		cfg_data = '0;
		cpb_r = 1;
		nbands_r = 1;
		shift_r = 0;
		row_now = 0;
		spectra_done = 0;
		for (r = 0; r < MAX_CHANNELS; r++) begin
			delay_mem[r] = '0;
			skip_mem[r] = 1'b0;
		end
		for (r = 0; r < DELAY_ROWS; r++)
			for (b = 0; b < MAX_BANDS; b++) sums[r][b] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: warm-up, extremes, clamping, ignored channel, zero registers
		plan = '{
			'{ROW_CFG,  KIND_TABLE,  0,    0,    0, 0,     REG_SHIFT, 2,     0, 0, 0},
			'{ROW_ITEM, KIND_SAMPLE, 0,    0,    0, 100,   REG_CPB,   0,     1, 0, 0},
			'{ROW_ITEM, KIND_SAMPLE, 0,    0,    0, 200,   REG_CPB,   0,     1, 0, 0},
			'{ROW_ITEM, KIND_SAMPLE, 0,    0,    0, 300,   REG_CPB,   0,     1, 1, 100},
			'{ROW_CFG,  KIND_TABLE,  0,    0,    0, 0,     REG_SHIFT, 0,     0, 0, 0},
			'{ROW_ITEM, KIND_SAMPLE, 0,    0,    0, 0,     REG_CPB,   0,     1, 1, 0},
			'{ROW_ITEM, KIND_SAMPLE, 0,    0,    0, 65535, REG_CPB,   0,     1, 1, 65535},
			'{ROW_ITEM, KIND_SAMPLE, 1023, 0,    0, 65535, REG_CPB,   0,     1, 0, 0},
			'{ROW_ITEM, KIND_TABLE,  0,    1023, 0, 0,     REG_CPB,   0,     1, 0, 0},
			'{ROW_ITEM, KIND_SAMPLE, 0,    0,    0, 12345, REG_CPB,   0,     1, 1, 12345},
			'{ROW_ITEM, KIND_TABLE,  0,    5,    1, 0,     REG_CPB,   0,     1, 0, 0},
			'{ROW_ITEM, KIND_SAMPLE, 0,    0,    0, 777,   REG_CPB,   0,     1, 1, 0},
			'{ROW_ITEM, KIND_TABLE,  1023, 1023, 1, 65535, REG_CPB,   0,     1, 0, 0},
			'{ROW_ITEM, KIND_TABLE,  0,    0,    0, 0,     REG_CPB,   0,     1, 0, 0},
			'{ROW_ITEM, KIND_SAMPLE, 0,    0,    0, 'hAAAA, REG_CPB,  0,     1, 1, 'hAAAA},
			'{ROW_CFG,  KIND_TABLE,  0,    0,    0, 0,     REG_CPB,   0,     0, 0, 0},
			'{ROW_CFG,  KIND_TABLE,  0,    0,    0, 0,     REG_BANDS, 0,     0, 0, 0},
			'{ROW_CFG,  KIND_TABLE,  0,    0,    0, 0,     REG_SPARE, 'h7FF, 0, 0, 0},
			'{ROW_ITEM, KIND_SAMPLE, 0,    0,    0, 'h5555, REG_CPB,  0,     1, 1, 'h5555},
			'{ROW_CFG,  KIND_TABLE,  0,    0,    0, 0,     REG_BANDS, 127,   0, 0, 0},
			'{ROW_ITEM, KIND_SAMPLE, 3,    0,    0, 500,   REG_CPB,   0,     0, 0, 0},
			'{ROW_ITEM, KIND_SAMPLE, 1,    0,    0, 40,    REG_CPB,   0,     0, 0, 0},
			'{ROW_ITEM, KIND_SAMPLE, 15,   0,    0, 9,     REG_CPB,   0,     0, 0, 0},
			'{ROW_ITEM, KIND_SAMPLE, 15,   0,    0, 65535, REG_CPB,   0,     0, 0, 0}
		};
		foreach (plan[i]) begin
			if (plan[i].op == ROW_CFG) begin
				quiesce();
				write_reg(plan[i].ridx, plan[i].rval);
			end else begin
				it = '{plan[i].kind, plan[i].channel, plan[i].dly, plan[i].skip, plan[i].smp};
				send_item(it, !plan[i].typed);
				if (plan[i].typed && plan[i].n_exp != 0)
					sums_due.push_back('{'0, plan[i].esum, 1'b1});
			end
		end

		// random spectra: a few fixed settings including extremes, then random
		fed = 0;
		run_phase(11'd1, 11'd1, 11'd0, 40, 1'b0);
		run_phase(11'd2, 11'd8, 11'd4, 60, 1'b1);
		run_phase(11'h000, 11'h780, 11'h7FF, 30, 1'b0);
		run_phase(11'd1024, 11'd64, 11'd3, 20, 1'b0);
		run_phase(11'd3, 11'd5, 11'd7, 50, 1'b0);
		while (fed < 420) begin
			cpb_v = ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 4));
			bands_v = {4'($urandom_range(0, 15)), ($urandom_range(0, 9) == 0) ?
				7'($urandom_range(17, 127)) : 7'($urandom_range(1, 16))};
			shift_v = {1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0) ?
				10'($urandom_range(13, 1023)) : 10'($urandom_range(0, 12))};
			run_phase(cpb_v, bands_v, shift_v, $urandom_range(40, 70), 1'b0);
		end

		// wind down
		item_valid <= 1'b0;
		for (n = 0; n < 20000 && sums_due.size() != 0; n++) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sums_due.size() != 0)
			flag_mismatch($sformatf("%0d sums never arrived", sums_due.size()));
		if (mismatches == 0)
			$display("subband_incoherent_dedisperser_core regression: pass");
		else
			$display("subband_incoherent_dedisperser_core regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/sid_pkg.sv
rtl/subband_incoherent_dedisperser_core.sv
dv/testbench.sv
